### sv/pid_pkg.sv
`default_nettype none

package pid_pkg;

   // field and register widths
   localparam int MEAS_W  = 16;
   localparam int LIM_W   = 16;
   localparam int DT_W    = 16;
   localparam int GAIN_W  = 24;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 24;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_SETPOINT    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_P      = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_I      = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_D      = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_STEP_PERIOD = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_LIMIT_LOW   = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_LIMIT_HIGH  = 3'd6;

   // register reset values
   localparam logic [DT_W-1:0]  STEP_PERIOD_RESET = 16'd655;
   localparam logic [LIM_W-1:0] LIMIT_LOW_RESET   = 16'hF800;
   localparam logic [LIM_W-1:0] LIMIT_HIGH_RESET  = 16'h0800;

   // datapath widths
   localparam int ERR_W     = MEAS_W + 1;
   localparam int MUL_A_W   = GAIN_W;
   localparam int MUL_B_W   = 34;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int EDT_W     = ERR_W + DT_W;
   localparam int PROP_W    = GAIN_W + ERR_W;
   localparam int INTEG_W   = 32;
   localparam int ISUM_W    = 47;
   localparam int TOT_W     = 62;

   // fixed point scaling
   localparam int P_SHIFT   = 4;
   localparam int INC_SHIFT = 12;
   localparam int LIM_SHIFT = 16;
   localparam int D_SHIFT   = 20;

   // derivative divider
   localparam int ABS_W          = 40;
   localparam int DIVN_W         = ABS_W + D_SHIFT;
   localparam int DIV_RADIX_BITS = 2;
   localparam int DIV_STEPS      = DIVN_W / DIV_RADIX_BITS;
   localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

   typedef struct packed {
      logic signed [MEAS_W-1:0] setpoint;
      logic signed [GAIN_W-1:0] gain_p;
      logic signed [GAIN_W-1:0] gain_i;
      logic signed [GAIN_W-1:0] gain_d;
      logic        [DT_W-1:0]   step_period;
      logic signed [LIM_W-1:0]  limit_low;
      logic signed [LIM_W-1:0]  limit_high;
   } cfg_type;

   // multiplier operand pairs
   typedef enum logic [1:0] {
      MUL_SEL_DIN   = 2'd0,
      MUL_SEL_EDT   = 2'd1,
      MUL_SEL_PROP  = 2'd2,
      MUL_SEL_INTEG = 2'd3
   } mul_sel_type;

   typedef struct packed {
      logic        load;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        div_init;
      logic        edt_cap;
      logic        prop_cap;
      logic        integ_upd;
      logic        div_step;
      logic        sum_en;
      logic        out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

### sv/pid_csr.sv
`default_nettype none

module pid_csr import pid_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write,
   input  wire logic [CSR_ADDR_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register write decode, unknown index ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_SETPOINT:    cfg_in.setpoint    = csr_data[MEAS_W-1:0];
            CSR_GAIN_P:      cfg_in.gain_p      = csr_data[GAIN_W-1:0];
            CSR_GAIN_I:      cfg_in.gain_i      = csr_data[GAIN_W-1:0];
            CSR_GAIN_D:      cfg_in.gain_d      = csr_data[GAIN_W-1:0];
            CSR_STEP_PERIOD: cfg_in.step_period = csr_data[DT_W-1:0];
            CSR_LIMIT_LOW:   cfg_in.limit_low   = csr_data[LIM_W-1:0];
            CSR_LIMIT_HIGH:  cfg_in.limit_high  = csr_data[LIM_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setpoint    <= '0;
         cfg_ff.gain_p      <= '0;
         cfg_ff.gain_i      <= '0;
         cfg_ff.gain_d      <= '0;
         cfg_ff.step_period <= STEP_PERIOD_RESET;
         cfg_ff.limit_low   <= LIMIT_LOW_RESET;
         cfg_ff.limit_high  <= LIMIT_HIGH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### sv/pid_ctrl.sv
`default_nettype none

module pid_ctrl import pid_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire dp_status_type status,
   output dp_cmd_type   cmd
);

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_MUL_D  = 9'b000000010,
      S_MUL_ED = 9'b000000100,
      S_MUL_P  = 9'b000001000,
      S_MUL_I  = 9'b000010000,
      S_INTEG  = 9'b000100000,
      S_DIV    = 9'b001000000,
      S_SUM    = 9'b010000000,
      S_CLAMP  = 9'b100000000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   // sequencing and datapath commands
   always_comb begin
      state_in     = state_ff;
      div_cnt_in   = div_cnt_ff;
      cmd          = '0;
      cmd.mul_sel  = MUL_SEL_DIN;
      unique case (state_ff)
         S_IDLE: begin
            cmd.load = accept;
            if (accept) state_in = S_MUL_D;
         end
         S_MUL_D: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_SEL_DIN;
            state_in    = S_MUL_ED;
         end
         S_MUL_ED: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = MUL_SEL_EDT;
            cmd.div_init = 1'b1;
            state_in     = S_MUL_P;
         end
         S_MUL_P: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_SEL_PROP;
            cmd.edt_cap = 1'b1;
            state_in    = S_MUL_I;
         end
         S_MUL_I: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = MUL_SEL_INTEG;
            cmd.prop_cap = 1'b1;
            state_in     = S_INTEG;
         end
         S_INTEG: begin
            cmd.integ_upd = 1'b1;
            div_cnt_in    = '0;
            state_in      = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               div_cnt_in = '0;
               state_in   = S_SUM;
            end else begin
               div_cnt_in = div_cnt_ff + 1'b1;
            end
         end
         S_SUM: begin
            cmd.sum_en = 1'b1;
            state_in   = S_CLAMP;
         end
         S_CLAMP: begin
            // wait for the output register to free up
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_MUL_D)
      else $error("accepted request did not start the multiply sequence");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> div_cnt_ff < DIV_CNT_W'(DIV_STEPS))
      else $error("divider step count ran past its end");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLAMP && status.out_free |=> state_ff == S_IDLE)
      else $error("result load did not return to idle");
`endif

endmodule

`default_nettype wire

### sv/pid_dp.sv
`default_nettype none

module pid_dp import pid_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cfg_type                  cfg,
   input  wire logic signed [MEAS_W-1:0] req_measurement,
   input  wire dp_cmd_type               cmd,
   output dp_status_type                 status,
   input  wire logic                     rsp_stall,
   output logic                          rsp_valid,
   output logic signed [MEAS_W-1:0]      rsp_drive
);

   logic signed [MEAS_W-1:0]  prev_ff;
   logic signed [ERR_W-1:0]   err_ff, din_ff;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  mul_ff;
   logic signed [EDT_W-1:0]   edt_ff;
   logic signed [PROP_W-1:0]  prop_ff;
   logic signed [INTEG_W-1:0] integ_ff, integ_in;
   logic        [DIVN_W-1:0]  num_ff, num_in, num_nx;
   logic        [DT_W-1:0]    rem_ff, rem_in, rem_nx;
   logic                      neg_ff;
   logic        [DT_W-1:0]    divisor;
   logic        [DT_W:0]      part;
   logic                      qbit;
   logic signed [PROP_W-1:0]  p_d;
   logic        [PROP_W-1:0]  p_abs;
   logic signed [ISUM_W-1:0]  isum;
   logic        [TOT_W-1:0]   prop_w, integ_w, quot_w, total_in;
   logic signed [TOT_W-1:0]   total_ff;
   logic signed [INTEG_W-1:0] out_clamped;
   logic                      rsp_valid_ff;
   logic signed [MEAS_W-1:0]  rsp_drive_ff;

   // clamp a Q.24 value to the Q8.8 limits, upper limit checked first
   function automatic logic signed [INTEG_W-1:0] clamp_q24(
      input logic signed [TOT_W-1:0] v,
      input logic signed [LIM_W-1:0] lo,
      input logic signed [LIM_W-1:0] hi
   );
      logic signed [TOT_W-1:0] lo_w;
      logic signed [TOT_W-1:0] hi_w;
      lo_w = {{(TOT_W-LIM_W-LIM_SHIFT){lo[LIM_W-1]}}, lo, {LIM_SHIFT{1'b0}}};
      hi_w = {{(TOT_W-LIM_W-LIM_SHIFT){hi[LIM_W-1]}}, hi, {LIM_SHIFT{1'b0}}};
      priority if (v > hi_w) clamp_q24 = hi_w[INTEG_W-1:0];
      else if (v < lo_w)     clamp_q24 = lo_w[INTEG_W-1:0];
      else                   clamp_q24 = v[INTEG_W-1:0];
   endfunction

   // shared multiplier operand select
   always_comb begin
      unique case (cmd.mul_sel)
         MUL_SEL_DIN: begin
            mul_a = cfg.gain_d;
            mul_b = {{(MUL_B_W-ERR_W){din_ff[ERR_W-1]}}, din_ff};
         end
         MUL_SEL_EDT: begin
            mul_a = {{(MUL_A_W-DT_W){1'b0}}, cfg.step_period};
            mul_b = {{(MUL_B_W-ERR_W){err_ff[ERR_W-1]}}, err_ff};
         end
         MUL_SEL_PROP: begin
            mul_a = cfg.gain_p;
            mul_b = {{(MUL_B_W-ERR_W){err_ff[ERR_W-1]}}, err_ff};
         end
         MUL_SEL_INTEG: begin
            mul_a = cfg.gain_i;
            mul_b = {{(MUL_B_W-EDT_W){edt_ff[EDT_W-1]}}, edt_ff};
         end
         default: begin
            mul_a = cfg.gain_d;
            mul_b = {{(MUL_B_W-ERR_W){din_ff[ERR_W-1]}}, din_ff};
         end
      endcase
   end

   // derivative dividend magnitude and sign
   assign p_d     = mul_ff[PROP_W-1:0];
   assign p_abs   = p_d[PROP_W-1] ? (~p_d + 1'b1) : p_d;
   assign divisor = (cfg.step_period == '0) ? DT_W'(1) : cfg.step_period;

   // two restoring division steps per cycle
   always_comb begin
      num_nx = num_ff;
      rem_nx = rem_ff;
      part   = '0;
      qbit   = 1'b0;
      for (int k = 0; k < DIV_RADIX_BITS; k++) begin
         part = {rem_nx, num_nx[DIVN_W-1]};
         if (part >= {1'b0, divisor}) begin
            part = part - {1'b0, divisor};
            qbit = 1'b1;
         end else begin
            qbit = 1'b0;
         end
         rem_nx = part[DT_W-1:0];
         num_nx = {num_nx[DIVN_W-2:0], qbit};
      end
   end

   always_comb begin
      num_in = num_ff;
      rem_in = rem_ff;
      if (cmd.div_init) begin
         num_in = {p_abs[ABS_W-1:0], {D_SHIFT{1'b0}}};
         rem_in = '0;
      end else if (cmd.div_step) begin
         num_in = num_nx;
         rem_in = rem_nx;
      end
   end

   // integral accumulate with anti-windup clamp
   assign isum     = ISUM_W'(integ_ff) + ISUM_W'(mul_ff >>> INC_SHIFT);
   assign integ_in = clamp_q24(TOT_W'(isum), cfg.limit_low, cfg.limit_high);

   // three term sum, derivative negated from the unsigned quotient
   assign prop_w  = {{(TOT_W-PROP_W-P_SHIFT){prop_ff[PROP_W-1]}}, prop_ff, {P_SHIFT{1'b0}}};
   assign integ_w = {{(TOT_W-INTEG_W){integ_ff[INTEG_W-1]}}, integ_ff};
   assign quot_w  = {{(TOT_W-DIVN_W){1'b0}}, num_ff};
   assign total_in = prop_w + integ_w + (neg_ff ? quot_w : ~quot_w) + TOT_W'(!neg_ff);

   assign out_clamped = clamp_q24(total_ff, cfg.limit_low, cfg.limit_high);

   // architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         integ_ff <= '0;
      end else begin
         if (cmd.load)      prev_ff  <= req_measurement;
         if (cmd.integ_upd) integ_ff <= integ_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         err_ff <= {cfg.setpoint[MEAS_W-1], cfg.setpoint}
                 - {req_measurement[MEAS_W-1], req_measurement};
         din_ff <= {req_measurement[MEAS_W-1], req_measurement}
                 - {prev_ff[MEAS_W-1], prev_ff};
      end
      if (cmd.mul_en)   mul_ff  <= mul_a * mul_b;
      if (cmd.div_init) neg_ff  <= p_d[PROP_W-1];
      if (cmd.edt_cap)  edt_ff  <= mul_ff[EDT_W-1:0];
      if (cmd.prop_cap) prop_ff <= mul_ff[PROP_W-1:0];
      if (cmd.sum_en)   total_ff <= total_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
   end

   // output register
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) rsp_drive_ff <= out_clamped[INTEG_W-1:LIM_SHIFT];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("result loaded over a stalled result");

   assert property (@(posedge clock) disable iff (reset)
      cmd.integ_upd |=> (integ_ff <= $signed({cfg.limit_high, {LIM_SHIFT{1'b0}}}))
         || (integ_ff == $signed({cfg.limit_low, {LIM_SHIFT{1'b0}}})))
      else $error("integral left above the upper limit");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_drive_ff))
      else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

### sv/pid_controller_clamped.sv
// PID controller with derivative on measurement and a clamped integral.
// Each request carries one signed Q8.8 measurement and gives one signed
// Q8.8 drive value: P = gain_p*(setpoint-measurement), an integral of
// gain_i*err*step_period clamped to [limit_low, limit_high], and
// D = -gain_d*(measurement-previous)/step_period, summed and clamped to the
// same limits. The block takes no new request until the current one is
// done, stepping through the shared multiplier states, the integral
// update, the derivative divider (two quotient bits a cycle), the sum and
// the clamp. The result sits in an output register, so the next request
// is taken while it waits; only a result still stalled when the following
// one is done holds the block. Registers are to be written through the csr
// port only while no request is in flight; the block does not enforce it.
// A step_period of zero adds nothing to the integral and divides D by one.
`default_nettype none

module pid_controller_clamped import pid_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic signed [MEAS_W-1:0] req_measurement,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [MEAS_W-1:0]      rsp_drive,
   input  wire logic                     csr_write,
   input  wire logic [CSR_ADDR_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]    csr_data
);

   cfg_type       cfg;
   dp_cmd_type    cmd;
   dp_status_type status;

   // configuration registers
   pid_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // sequencer
   pid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic and state
   pid_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_measurement (req_measurement),
      .cmd             (cmd),
      .status          (status),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_drive       (rsp_drive)
   );

endmodule

`default_nettype wire
